FILE: sv/pbfs_pkg.sv
// Shared constants, types and register codes for the periodic B-spline flow scale block.
package pbfs_pkg;

  localparam int FRAC_BITS = 16;          // fraction bits of one basis weight
  localparam int NUM_KNOTS = 4;
  localparam int PHASE_W   = 17;
  localparam int OUT_W     = 18;
  localparam int GAIN_W    = 16;
  localparam int KNOT_STEP = 16384;
  localparam int INT_FRAC  = 48;          // fraction bits of six times the basis
  localparam int DSH       = INT_FRAC - FRAC_BITS;
  localparam int QW        = FRAC_BITS + 3;
  localparam int PW        = FRAC_BITS + GAIN_W;
  localparam int AW        = FRAC_BITS + 18;
  localparam int RSH       = FRAC_BITS - 2;
  localparam int LATENCY   = 8;

  localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(65536);
  localparam logic [OUT_W-1:0]   OUT_MAX    = OUT_W'(131072);
  localparam logic [GAIN_W-1:0]  GAIN_RESET = GAIN_W'(16384);

  // ceil(2^(FRAC_BITS+3) / 3): exact floor division by three for values below 2^(FRAC_BITS+2)
  localparam logic [FRAC_BITS+1:0] RECIP =
    (FRAC_BITS+2)'(((64'd1 << (FRAC_BITS + 3)) + 64'd2) / 64'd3);

  typedef enum logic [1:0] {
    REG_GAIN_ONE,
    REG_GAIN_TWO,
    REG_GAIN_THREE,
    REG_GAIN_FOUR
  } reg_idx_t;

  // Folded spline argument of one knot: inner segments use the middle polynomial
  typedef struct packed {
    logic [16:0] x;
    logic        outer;
    logic        zero;
  } lane_t;

  typedef lane_t [NUM_KNOTS-1:0] lane_arr_t;
  typedef logic [NUM_KNOTS-1:0][GAIN_W-1:0] gain_arr_t;
  typedef logic [NUM_KNOTS-1:0][FRAC_BITS-1:0] weight_arr_t;

endpackage

FILE: sv/pbfs_regs.sv
// Gain registers behind the APB-style configuration port.
module pbfs_regs (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output pbfs_pkg::gain_arr_t      gains
);

  logic                 wr;
  pbfs_pkg::reg_idx_t   idx;

  assign wr  = psel & penable & pwrite;
  assign idx = pbfs_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < pbfs_pkg::NUM_KNOTS; j++) begin
        gains[j] <= pbfs_pkg::GAIN_RESET;
      end
    end else if (wr) begin
      case (idx)
        pbfs_pkg::REG_GAIN_ONE:   gains[0] <= pwdata[15:0];
        pbfs_pkg::REG_GAIN_TWO:   gains[1] <= pwdata[15:0];
        pbfs_pkg::REG_GAIN_THREE: gains[2] <= pwdata[15:0];
        pbfs_pkg::REG_GAIN_FOUR:  gains[3] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign prdata = {16'b0, gains[paddr[3:2]]};

endmodule

FILE: sv/pbfs_front.sv
// Phase clamp, per-knot wrap and folding of the spline argument onto two polynomials.
module pbfs_front (
  input  logic                    clk,
  input  logic [16:0]             time_phase,
  output pbfs_pkg::lane_arr_t     lanes
);

  pbfs_pkg::lane_arr_t lanes_next;

  always_comb begin
    logic [16:0]        phase_c;
    logic signed [19:0] p;
    logic signed [19:0] knot;
    logic signed [19:0] t;
    logic signed [19:0] d;
    logic signed [19:0] sv;
    logic [2:0]         kk;
    logic [15:0]        f;
    phase_c = (time_phase > pbfs_pkg::PHASE_ONE) ? pbfs_pkg::PHASE_ONE : time_phase;
    p = signed'({3'b0, phase_c});
    for (int j = 0; j < pbfs_pkg::NUM_KNOTS; j++) begin
      knot = 20'(pbfs_pkg::KNOT_STEP * (j + 1));
      // wrap the phase to within half a period of this knot
      if (p > knot + 20'sd32768) begin
        t = p - 20'sd65536;
      end else if (p < knot - 20'sd32768) begin
        t = p + 20'sd65536;
      end else begin
        t = p;
      end
      d  = knot - t;
      sv = (d <<< 2) + 20'sd131072;
      kk = sv[18:16];
      f  = sv[15:0];
      // mirror the upper half onto the lower: B(s) = B(4 - s)
      lanes_next[j].x     = (kk == 3'd0 || kk == 3'd1) ? {1'b0, f} : (17'd65536 - {1'b0, f});
      lanes_next[j].outer = (kk == 3'd0) || (kk == 3'd3);
      lanes_next[j].zero  = kk[2];
    end
  end

  always_ff @(posedge clk) begin
    lanes <= lanes_next;
  end

endmodule

FILE: sv/pbfs_basis.sv
// Five-stage basis lane: square, cube, polynomial, scale to weight, divide by six.
module pbfs_basis (
  input  logic                              clk,
  input  pbfs_pkg::lane_t                   lane,
  output logic [pbfs_pkg::FRAC_BITS-1:0]    weight
);

  localparam int FB = pbfs_pkg::FRAC_BITS;
  localparam int MW = 2 * FB + 4;

  // square stage
  logic [16:0] x_s2;
  logic        outer_s2;
  logic        zero_s2;
  logic [32:0] sq_s2;
  // cube stage
  logic [16:0] x_s3;
  logic        outer_s3;
  logic        zero_s3;
  logic [32:0] sq_s3;
  logic [48:0] cube_s3;
  // polynomial terms
  logic [51:0] t0_s4;
  logic [51:0] t1_s4;
  logic        zero_s4;
  // six times the weight, rounded
  logic [pbfs_pkg::QW-1:0] q_s5;

  logic [32:0]  xe;
  logic [49:0]  cube_full;
  logic [51:0]  t0_next;
  logic [51:0]  t1_next;
  logic [51:0]  sum;
  logic [MW-1:0] div_full;

  assign xe        = 33'(lane.x);
  assign cube_full = 50'(sq_s2) * 50'(x_s2);

  always_comb begin
    logic [51:0] x1w;
    logic [51:0] x2w;
    logic [51:0] x3w;
    logic [51:0] rnd;
    x1w = 52'(x_s3);
    x2w = 52'(sq_s3);
    x3w = 52'(cube_s3);
    rnd = 52'(3) << pbfs_pkg::DSH;
    if (outer_s3) begin
      t1_next = x3w;
      t0_next = rnd;
    end else begin
      // 1 + 3x + 3x^2 - 3x^3, modulo 2^52; the true value is never negative
      t1_next = (((x2w << 1) + x2w) << 16) - ((x3w << 1) + x3w);
      t0_next = (52'(1) << 48) + (((x1w << 1) + x1w) << 32) + rnd;
    end
  end

  assign sum      = t0_s4 + t1_s4;
  assign div_full = MW'(q_s5[pbfs_pkg::QW-1:1]) * MW'(pbfs_pkg::RECIP);

  always_ff @(posedge clk) begin
    x_s2     <= lane.x;
    outer_s2 <= lane.outer;
    zero_s2  <= lane.zero;
    sq_s2    <= xe * xe;

    x_s3     <= x_s2;
    outer_s3 <= outer_s2;
    zero_s3  <= zero_s2;
    sq_s3    <= sq_s2;
    cube_s3  <= cube_full[48:0];

    t0_s4    <= t0_next;
    t1_s4    <= t1_next;
    zero_s4  <= zero_s3;

    q_s5     <= zero_s4 ? '0 : sum[pbfs_pkg::DSH +: pbfs_pkg::QW];

    // divide by six: drop one bit, then multiply by the reciprocal of three
    weight   <= div_full[FB+3 +: FB];
  end

endmodule

FILE: sv/pbfs_blend.sv
// Gain multiply, four-way sum, rounding and saturation of the scale factor.
module pbfs_blend (
  input  logic                    clk,
  input  pbfs_pkg::weight_arr_t   weights,
  input  pbfs_pkg::gain_arr_t     gains,
  output logic [17:0]             scale_factor
);

  localparam int RW = pbfs_pkg::AW - pbfs_pkg::RSH;

  logic [pbfs_pkg::PW-1:0] prod [pbfs_pkg::NUM_KNOTS];
  logic [pbfs_pkg::AW-1:0] acc;
  logic [RW-1:0]           res;

  always_comb begin
    acc = pbfs_pkg::AW'(1) << (pbfs_pkg::RSH - 1);
    for (int j = 0; j < pbfs_pkg::NUM_KNOTS; j++) begin
      acc = acc + pbfs_pkg::AW'(prod[j]);
    end
  end

  assign res = acc[pbfs_pkg::AW-1:pbfs_pkg::RSH];

  always_ff @(posedge clk) begin
    for (int j = 0; j < pbfs_pkg::NUM_KNOTS; j++) begin
      prod[j] <= pbfs_pkg::PW'(weights[j]) * pbfs_pkg::PW'(gains[j]);
    end
    scale_factor <= (res > RW'(pbfs_pkg::OUT_MAX)) ? pbfs_pkg::OUT_MAX : res[17:0];
  end

endmodule

FILE: sv/periodic_bspline_flow_scale.sv
// Periodic flow scale factor from four uniform cubic B-spline knots.
//
// Usage: drive time_phase (17 bits, 16 fraction bits, values above 1.0 are
// clamped) and raise start; the item is taken at a clock edge where start is
// high and busy is low. busy is low except while rst is high, so a new phase
// may be taken in every cycle: one item per cycle, sustained.
// done pulses for one cycle when a transfer's result leaves the pipeline,
// with scale_factor (18 bits, 16 fraction bits, saturated at 2.0) valid in
// that cycle only. Data pass the front fold register, then the chain of each
// knot lane: square, cube, polynomial terms, divide-by-six reciprocal, gain.
// The receiver cannot stall; results are presented in input order.
// Gains are written through the APB-style port (4 registers at byte addresses
// 0, 4, 8, 12, low 16 bits used); write them only with no item in flight.
// Synchronous reset clears the in-flight valid bits and loads every gain with
// 1.0; items in flight at reset are dropped.
module periodic_bspline_flow_scale (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [16:0] time_phase,
  output logic        done,
  output logic [17:0] scale_factor,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pbfs_pkg::lane_arr_t    lanes;
  pbfs_pkg::weight_arr_t  weights;
  pbfs_pkg::gain_arr_t    gains;
  logic [pbfs_pkg::LATENCY-1:0] vld;
  logic                   accept;

  assign busy   = rst;
  assign pready = 1'b1;
  assign accept = start & ~busy;

  // valid bits advance alongside the data stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[pbfs_pkg::LATENCY-2:0], accept};
    end
  end

  assign done = vld[pbfs_pkg::LATENCY-1];

  pbfs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .gains   (gains)
  );

  pbfs_front u_front (
    .clk        (clk),
    .time_phase (time_phase),
    .lanes      (lanes)
  );

  for (genvar j = 0; j < pbfs_pkg::NUM_KNOTS; j++) begin : g_lane
    pbfs_basis u_basis (
      .clk    (clk),
      .lane   (lanes[j]),
      .weight (weights[j])
    );
  end

  pbfs_blend u_blend (
    .clk          (clk),
    .weights      (weights),
    .gains        (gains),
    .scale_factor (scale_factor)
  );

  a_done_follows_transfer: assert property (
    @(posedge clk) disable iff (rst)
    accept |-> ##(pbfs_pkg::LATENCY) done
  ) else $error("missing result after transfer");

  a_done_has_transfer: assert property (
    @(posedge clk) disable iff (rst)
    done |-> $past(accept, pbfs_pkg::LATENCY)
  ) else $error("result without matching transfer");

  a_saturated: assert property (
    @(posedge clk) disable iff (rst)
    done |-> (scale_factor <= pbfs_pkg::OUT_MAX)
  ) else $error("scale factor above saturation limit");

endmodule
